[rtl/load_cell_adc_serial_reader_core_defines.svh]
// ----------------------------------------------------------------------------
// load_cell_adc_serial_reader_core_defines
// assertion macros for the load cell converter reader
// ----------------------------------------------------------------------------
`ifndef LOAD_CELL_ADC_SERIAL_READER_CORE_DEFINES_SVH
`define LOAD_CELL_ADC_SERIAL_READER_CORE_DEFINES_SVH

// check held outside reset
`define LCASR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check that also holds during reset
`define LCASR_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/lcasr_pkg.sv]
// ----------------------------------------------------------------------------
// lcasr_pkg
// shared widths, codes and types of the load cell converter reader
// ----------------------------------------------------------------------------
package lcasr_pkg;

   localparam int KEPT_BITS_DEFAULT = 17;
   localparam int CSR_INDEX_W       = 2;
   localparam int DATA_W            = 32;
   localparam int DATA_PULSES       = 25;
   localparam logic [DATA_W-1:0] ALL_ONES = '1;

   // commands
   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_START = 2'd1,
      CMD_PDOWN = 2'd2,
      CMD_SPARE = 2'd3
   } cmd_type;

   // gain codes
   typedef enum logic [1:0] {
      GAIN_A128  = 2'd0,
      GAIN_B32   = 2'd1,
      GAIN_A64   = 2'd2,
      GAIN_SPARE = 2'd3
   } gain_type;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_OFFSET_A = 2'd0,
      REG_SCALE_A  = 2'd1,
      REG_OFFSET_B = 2'd2,
      REG_SCALE_B  = 2'd3
   } reg_index_type;

   // first stage of the result pipe, before the scale multiply
   typedef struct packed {
      logic              sck;
      logic              busy_res;
      logic              result_valid;
      logic              reading_channel;
      logic              calibrated;
      logic [DATA_W-1:0] diff;
      logic [DATA_W-1:0] scale;
      logic [DATA_W-1:0] shifted;
   } stage_type;

endpackage

[rtl/lcasr_intf.sv]
// ----------------------------------------------------------------------------
// lcasr_intf
// tick, result and register write channels of the load cell converter reader
// ----------------------------------------------------------------------------
interface lcasr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [1:0] next_gain;
   logic       dout;

   modport source (output valid, output cmd, output next_gain, output dout, input ready);
   modport sink   (input valid, input cmd, input next_gain, input dout, output ready);
endinterface

interface lcasr_rsp_if;
   logic        valid;
   logic        ready;
   logic        sck;
   logic        busy_res;
   logic        result_valid;
   logic [31:0] reading;
   logic        reading_channel;

   modport source (output valid, output sck, output busy_res, output result_valid,
                   output reading, output reading_channel, input ready);
   modport sink   (input valid, input sck, input busy_res, input result_valid,
                   input reading, input reading_channel, output ready);
endinterface

interface lcasr_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [31:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/load_cell_adc_serial_reader_core.sv]
// ----------------------------------------------------------------------------
// load_cell_adc_serial_reader_core
// two-wire readout of a 24-bit bridge converter with offset and scale
// ----------------------------------------------------------------------------
// Usage:
//   req carries one half-period tick of the converter clock per word: a
//   command, the gain wanted for the next conversion and the data pin level.
//   rsp returns exactly one word per tick: the clock level to drive, busy,
//   and on the tick that ends the last gain pulse a finished reading.
//   csr writes offset_a, scale_a, offset_b, scale_b (index 0 to 3), always ready;
//   the user must see it is written only while the block is idle; nothing enforces it.
// Throughput: one tick per cycle while req.ready stays high; sequencing state
//   updates when the tick is taken, so back to back ticks need no gaps.
// Pipe: a taken tick is registered in the stage register, then in the output
//   register that drives rsp: one stage for the sequencer and offset subtract,
//   one for the 32x32 scale multiply.
// Reset: calibration registers go to all ones (uncalibrated), the sequencer
//   powers down with the clock high and gain A128, the pipe empties.
// Stall: while rsp.ready is low the output register holds its word, the
//   stage before it fills, and then req.ready drops until space frees up.
// ----------------------------------------------------------------------------
module load_cell_adc_serial_reader_core
   import lcasr_pkg::*;
#(
   parameter int KEPT_BITS = KEPT_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   lcasr_req_if.sink    req,
   lcasr_rsp_if.source  rsp,
   lcasr_csr_if.sink    csr
);

`include "load_cell_adc_serial_reader_core_defines.svh"

   localparam int RAW_W = KEPT_BITS + 2;
   localparam logic [4:0] PULSE_END = 5'(DATA_PULSES);

   typedef enum logic [2:0] {
      ST_PDOWN = 3'd0,
      ST_IDLE  = 3'd1,
      ST_WAIT  = 3'd2,
      ST_READ  = 3'd3,
      ST_GAIN  = 3'd4
   } mode_type;

   // calibration registers
   logic [DATA_W-1:0] offset_a_ff, scale_a_ff, offset_b_ff, scale_b_ff;

   // sequencer state
   mode_type         mode_ff, mode_in;
   logic [RAW_W-1:0] raw_bits_ff, raw_bits_in;
   logic [4:0]       pulse_count_ff, pulse_count_in;
   logic             clock_phase_ff, clock_phase_in;
   logic [1:0]       accuracy_ff, accuracy_in;
   logic             channel_ff, channel_in;
   logic [1:0]       pending_gain_ff, pending_gain_in;

   // pipe
   stage_type         stage_ff, stage_in;
   logic              stage_vld_ff;
   logic              out_vld_ff;
   logic              out_sck_ff, out_busy_ff, out_valid_ff, out_chan_ff;
   logic [DATA_W-1:0] out_reading_ff, out_reading_in;
   logic [DATA_W-1:0] product;
   logic              advance;
   logic              take;

   // check terms
   logic              stalled;
   logic              gain_count_ok;

   // handshakes
   assign advance   = !out_vld_ff || rsp.ready;
   assign req.ready = !stage_vld_ff || advance;
   assign take      = req.valid && req.ready;
   assign csr.ready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_a_ff <= ALL_ONES;
         scale_a_ff  <= ALL_ONES;
         offset_b_ff <= ALL_ONES;
         scale_b_ff  <= ALL_ONES;
      end else if (csr.valid) begin
         case (reg_index_type'(csr.index))
            REG_OFFSET_A: offset_a_ff <= csr.data;
            REG_SCALE_A:  scale_a_ff  <= csr.data;
            REG_OFFSET_B: offset_b_ff <= csr.data;
            REG_SCALE_B:  scale_b_ff  <= csr.data;
            default: ;
         endcase
      end
   end

   // sequencer next state and first stage word
   always_comb begin
      logic             fin;
      logic [DATA_W-1:0] off;
      logic [DATA_W-1:0] scl;
      logic [5:0]       bit_limit;
      fin             = 1'b0;
      mode_in         = mode_ff;
      raw_bits_in     = raw_bits_ff;
      pulse_count_in  = pulse_count_ff;
      clock_phase_in  = clock_phase_ff;
      accuracy_in     = accuracy_ff;
      channel_in      = channel_ff;
      pending_gain_in = pending_gain_ff;
      stage_in        = '0;
      bit_limit       = 6'(KEPT_BITS) + {4'd0, accuracy_ff};

      case (mode_ff)
         ST_IDLE, ST_PDOWN: begin
            if (cmd_type'(req.cmd) == CMD_START) begin
               mode_in           = ST_WAIT;
               stage_in.busy_res = 1'b1;
            end else if (cmd_type'(req.cmd) == CMD_PDOWN || mode_ff == ST_PDOWN) begin
               mode_in      = ST_PDOWN;
               accuracy_in  = 2'd0;
               channel_in   = 1'b0;
               stage_in.sck = 1'b1;
            end
         end
         ST_WAIT: begin
            stage_in.busy_res = 1'b1;
            if (!req.dout) begin
               mode_in        = ST_READ;
               raw_bits_in    = '0;
               pulse_count_in = '0;
               clock_phase_in = 1'b0;
            end
         end
         ST_READ: begin
            stage_in.busy_res = 1'b1;
            if (!clock_phase_ff) begin
               stage_in.sck = 1'b1;
               // sample while data bits remain, first bit inverted
               if ({1'b0, pulse_count_ff} < bit_limit) begin
                  raw_bits_in = {raw_bits_ff[RAW_W-2:0],
                                 req.dout ^ (pulse_count_ff == 5'd0)};
               end
               clock_phase_in = 1'b1;
            end else begin
               clock_phase_in = 1'b0;
               pulse_count_in = pulse_count_ff + 5'd1;
               if (pulse_count_in >= 5'(DATA_PULSES)) begin
                  pending_gain_in = (gain_type'(req.next_gain) == GAIN_SPARE) ?
                                    2'd0 : req.next_gain;
                  pulse_count_in  = '0;
                  mode_in         = ST_GAIN;
               end
            end
         end
         ST_GAIN: begin
            stage_in.busy_res = 1'b1;
            if (!clock_phase_ff) begin
               stage_in.sck   = 1'b1;
               clock_phase_in = 1'b1;
            end else begin
               clock_phase_in = 1'b0;
               pulse_count_in = pulse_count_ff + 5'd1;
               if (pulse_count_in >= {3'd0, pending_gain_ff} + 5'd1) begin
                  fin            = 1'b1;
                  pulse_count_in = '0;
                  mode_in        = ST_IDLE;
                  // gain map for the next conversion
                  case (gain_type'(pending_gain_ff))
                     GAIN_B32: begin
                        accuracy_in = 2'd2;
                        channel_in  = 1'b1;
                     end
                     GAIN_A64: begin
                        accuracy_in = 2'd1;
                        channel_in  = 1'b0;
                     end
                     default: begin
                        accuracy_in = 2'd0;
                        channel_in  = 1'b0;
                     end
                  endcase
               end
            end
         end
         default: begin
            mode_in      = ST_PDOWN;
            stage_in.sck = 1'b1;
         end
      endcase

      // reading operands use the channel and accuracy of this read
      off = channel_ff ? offset_b_ff : offset_a_ff;
      scl = channel_ff ? scale_b_ff : scale_a_ff;
      if (fin) begin
         stage_in.busy_res        = 1'b0;
         stage_in.result_valid    = 1'b1;
         stage_in.reading_channel = channel_ff;
         stage_in.calibrated      = (off != ALL_ONES) && (scl != ALL_ONES);
         stage_in.diff            = DATA_W'(raw_bits_ff) - (off << accuracy_ff);
         stage_in.scale           = scl;
         stage_in.shifted         = DATA_W'(raw_bits_ff) >> ({1'b0, accuracy_ff} + 3'd3);
      end
   end

   // scale multiply, low word only
   assign product = DATA_W'(stage_ff.diff * stage_ff.scale);

   always_comb begin
      out_reading_in = '0;
      if (stage_ff.result_valid) begin
         out_reading_in = stage_ff.calibrated ? (product >> 8) : stage_ff.shifted;
      end
   end

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= ST_PDOWN;
         raw_bits_ff     <= '0;
         pulse_count_ff  <= '0;
         clock_phase_ff  <= 1'b0;
         accuracy_ff     <= 2'd0;
         channel_ff      <= 1'b0;
         pending_gain_ff <= 2'd0;
      end else if (take) begin
         mode_ff         <= mode_in;
         raw_bits_ff     <= raw_bits_in;
         pulse_count_ff  <= pulse_count_in;
         clock_phase_ff  <= clock_phase_in;
         accuracy_ff     <= accuracy_in;
         channel_ff      <= channel_in;
         pending_gain_ff <= pending_gain_in;
      end
   end

   // pipe valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff <= 1'b0;
         out_vld_ff   <= 1'b0;
      end else begin
         if (take) begin
            stage_vld_ff <= 1'b1;
         end else if (advance) begin
            stage_vld_ff <= 1'b0;
         end
         if (advance) begin
            out_vld_ff <= stage_vld_ff;
         end
      end
   end

   // pipe payload
   always_ff @(posedge clock) begin
      if (take) begin
         stage_ff <= stage_in;
      end
      if (advance && stage_vld_ff) begin
         out_sck_ff     <= stage_ff.sck;
         out_busy_ff    <= stage_ff.busy_res;
         out_valid_ff   <= stage_ff.result_valid;
         out_chan_ff    <= stage_ff.reading_channel;
         out_reading_ff <= out_reading_in;
      end
   end

   assign rsp.valid           = out_vld_ff;
   assign rsp.sck             = out_sck_ff;
   assign rsp.busy_res        = out_busy_ff;
   assign rsp.result_valid    = out_valid_ff;
   assign rsp.reading         = out_reading_ff;
   assign rsp.reading_channel = out_chan_ff;

   // checks
   assign stalled       = stage_vld_ff && !advance;
   assign gain_count_ok = pulse_count_ff <= 5'(pending_gain_ff);

   `LCASR_ASSERT(a_read_count, mode_ff == ST_READ |-> pulse_count_ff < PULSE_END, "read overrun")
   `LCASR_ASSERT(a_gain_count, mode_ff == ST_GAIN |-> gain_count_ok, "gain overrun")
   `LCASR_ASSERT(a_stage_hold, stalled |=> stage_vld_ff && $stable(stage_ff), "stage lost word")
   `LCASR_ASSERT_ALWAYS(a_ready_empty, !stage_vld_ff |-> req.ready, "empty stage refused a tick")

endmodule
